// ===== hw/rtl/lmv_pkg.sv =====
// ----------------------------------------------------------------------------
// lmv_pkg: shared types and constants of the local mean/variance filter
// Register indexes, field widths, defaults and controller/datapath structs.
// ----------------------------------------------------------------------------
package lmv_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HALF_DEF   = 7;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int HALF_W     = 3;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 12;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int MEAN_W     = 16;
  localparam int VAR_W      = 23;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
  localparam logic [VAR_W-1:0]  VAR_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_SIZE    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic accept;
    logic rd_step;
    logic mul;
    logic sub;
    logic div_mean;
    logic div_var;
    logic save_mean;
    logic save_var;
    logic load_out;
  } lmv_cmd_t;

  typedef struct packed {
    logic emit;
    logic rd_last;
    logic div_busy;
    logic out_free;
  } lmv_sts_t;

endpackage

// ===== hw/rtl/lmv_if.sv =====
// ----------------------------------------------------------------------------
// lmv_if: stream channels of the local mean/variance filter
// Pixel input channel and window result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lmv_in_if #(
  parameter int PIXEL_BITS = lmv_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  frame_start;

  modport source(output valid, pixel, frame_start, input ready);
  modport sink(input valid, pixel, frame_start, output ready);
endinterface

interface lmv_out_if #(
  parameter int X_W = 10
);
  logic                         valid;
  logic                         ready;
  logic [X_W-1:0]               center_x;
  logic [lmv_pkg::ROW_W-1:0]    center_y;
  logic [lmv_pkg::MEAN_W-1:0]   mean_q8;
  logic [lmv_pkg::VAR_W-1:0]    variance_q8;

  modport source(output valid, center_x, center_y, mean_q8, variance_q8, input ready);
  modport sink(input valid, center_x, center_y, mean_q8, variance_q8, output ready);
endinterface

// ===== hw/rtl/local_mean_variance_filter.sv =====
// ----------------------------------------------------------------------------
// local_mean_variance_filter: sliding-window local mean and sample variance
// Line-buffered raster filter emitting Q8 mean and variance per interior pixel.
// ----------------------------------------------------------------------------
// A pixel that completes no window is taken without leaving the idle state.
// A pixel that completes a window makes N = (2h+1)^2 line store reads
// through the single read port and D = 40 steps of the one-bit-per-cycle
// divider, run once for the mean and once for the variance. The result register
// frees the input side while a beat waits. Synchronous reset clears position,
// configuration (h=1, 640x480) and control; line store contents are not reset.
module local_mean_variance_filter #(
  parameter int MAX_WIDTH  = lmv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HALF   = lmv_pkg::MAX_HALF_DEF,
  parameter int PIXEL_BITS = lmv_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmv_pkg::CFG_DATA_W-1:0] cfg_data,
  lmv_in_if.sink                         in_ch,
  lmv_out_if.source                      out_ch
);
  import lmv_pkg::*;

  lmv_cmd_t cmd;
  lmv_sts_t sts;

  lmv_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lmv_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (in_ch.pixel),
    .frame_start(in_ch.frame_start),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .center_x   (out_ch.center_x),
    .center_y   (out_ch.center_y),
    .mean_q8    (out_ch.mean_q8),
    .variance_q8(out_ch.variance_q8)
  );
endmodule

// ===== hw/rtl/lmv_ram.sv =====
// ----------------------------------------------------------------------------
// lmv_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hw/rtl/lmv_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmv_ctrl: sequencer of the local mean/variance filter
// Stores each pixel; window pixels go on to read, products, two divides, output.
// ----------------------------------------------------------------------------
module lmv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lmv_pkg::lmv_sts_t sts,
  output lmv_pkg::lmv_cmd_t cmd
);
  import lmv_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_SUB   = 8'b0001_0000,
    S_DIVM  = 8'b0010_0000,
    S_DIVV  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.emit) begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_step = 1'b1;
        if (sts.rd_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_MUL;
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.sub      = 1'b1;
        cmd.div_mean = 1'b1;
        state_next   = S_DIVM;
      end
      S_DIVM: begin
        if (!sts.div_busy) begin
          cmd.save_mean = 1'b1;
          cmd.div_var   = 1'b1;
          state_next    = S_DIVV;
        end
      end
      S_DIVV: begin
        if (!sts.div_busy) begin
          cmd.save_var = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/lmv_datapath.sv =====
// ----------------------------------------------------------------------------
// lmv_datapath: position tracking, line store, window sums and divider
// Holds the configuration, the raster position, the sums and the result beat.
// ----------------------------------------------------------------------------
module lmv_datapath #(
  parameter int MAX_WIDTH  = lmv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HALF   = lmv_pkg::MAX_HALF_DEF,
  parameter int PIXEL_BITS = lmv_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [PIXEL_BITS-1:0]              pixel,
  input  logic                               frame_start,
  input  lmv_pkg::lmv_cmd_t                  cmd,
  output lmv_pkg::lmv_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]       center_x,
  output logic [lmv_pkg::ROW_W-1:0]          center_y,
  output logic [lmv_pkg::MEAN_W-1:0]         mean_q8,
  output logic [lmv_pkg::VAR_W-1:0]          variance_q8
);
  import lmv_pkg::*;

  localparam int WIN_ROWS = 2 * MAX_HALF + 1;
  localparam int SLOT_W   = $clog2(WIN_ROWS);
  localparam int X_W      = $clog2(MAX_WIDTH);
  localparam int DEPTH    = WIN_ROWS * MAX_WIDTH;
  localparam int AW       = $clog2(DEPTH);
  localparam int HB       = $clog2(MAX_HALF + 1);
  localparam int SPAN_W   = HB + 1;
  localparam int NB       = $clog2(WIN_ROWS * WIN_ROWS + 1);
  localparam int SB       = PIXEL_BITS + NB;
  localparam int QB       = 2 * PIXEL_BITS + NB;
  localparam int NUM_W    = QB + NB;
  localparam int DVW      = NUM_W + 8;
  localparam int DNW      = 2 * NB;
  localparam int CNT_W    = $clog2(DVW + 1);
  localparam int EW       = (X_W + 1 > IMG_W_W) ? X_W + 1 : IMG_W_W;
  localparam int HW       = ROW_W + 1;

  // Configuration registers.
  logic [HALF_W-1:0]  half_reg;
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_reg   <= HALF_W'(1);
      width_reg  <= IMG_W_W'(640);
      height_reg <= IMG_H_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_SIZE:    half_reg   <= cfg_data[HALF_W-1:0];
        REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  logic [HB-1:0]     h_eff;
  logic [SPAN_W-1:0] span;
  logic [EW-1:0]     w_eff;
  logic [HW-1:0]     ht_eff;

  always_comb begin
    if (half_reg == '0) begin
      h_eff = HB'(1);
    end else if (int'(half_reg) > MAX_HALF) begin
      h_eff = HB'(MAX_HALF);
    end else begin
      h_eff = HB'(half_reg);
    end
    span = {h_eff, 1'b0};
    if (width_reg == '0) begin
      w_eff = EW'(1);
    end else if (EW'(width_reg) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_reg);
    end
    ht_eff = (height_reg == '0) ? HW'(1) : HW'(height_reg);
  end

  // Raster position; slot follows the row modulo the number of stored rows.
  logic [X_W-1:0]    col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [X_W-1:0]    x_cur;
  logic [ROW_W-1:0]  y_cur;
  logic [SLOT_W-1:0] sl_cur;
  logic [EW-1:0]     x_inc;
  logic [HW-1:0]     y_inc;

  always_comb begin
    x_cur  = frame_start ? '0 : col;
    y_cur  = frame_start ? '0 : row;
    sl_cur = frame_start ? '0 : slot;
    x_inc  = EW'(x_cur) + EW'(1);
    y_inc  = HW'(y_cur) + HW'(1);
    col_next  = x_inc[X_W-1:0];
    row_next  = y_cur;
    slot_next = sl_cur;
    if (x_inc >= w_eff) begin
      col_next = '0;
      if (y_inc >= ht_eff) begin
        row_next  = '0;
        slot_next = '0;
      end else begin
        row_next  = y_inc[ROW_W-1:0];
        slot_next = (int'(sl_cur) == WIN_ROWS - 1) ? '0 : sl_cur + SLOT_W'(1);
      end
    end
  end

  assign sts.emit = (EW'(x_cur) >= EW'(span)) && (HW'(y_cur) >= HW'(span));

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (cmd.accept) begin
      col  <= col_next;
      row  <= row_next;
      slot <= slot_next;
    end
  end

  // Window geometry of the current item.
  logic [X_W-1:0]    xl;
  logic [ROW_W-1:0]  yl;
  logic [SLOT_W-1:0] sl_l;
  logic [SPAN_W-1:0] span_l;
  logic [HB-1:0]     h_l;
  logic [NB-1:0]     n_reg;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      xl     <= x_cur;
      yl     <= y_cur;
      sl_l   <= sl_cur;
      span_l <= span;
      h_l    <= h_eff;
      n_reg  <= NB'((int'(span) + 1) * (int'(span) + 1));
    end
  end

  // Window read sweep.
  logic [SPAN_W-1:0]    rr, cc;
  logic                 rd_pend;
  int                   slot_sum;
  logic [SLOT_W-1:0]    rd_slot;
  logic [X_W-1:0]       rd_col;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [PIXEL_BITS-1:0] rd_data;

  always_comb begin
    slot_sum = int'(sl_l) + WIN_ROWS - int'(span_l) + int'(rr);
    if (slot_sum >= WIN_ROWS) begin
      slot_sum = slot_sum - WIN_ROWS;
    end
    rd_slot = SLOT_W'(slot_sum);
    rd_col  = X_W'(int'(xl) - int'(span_l) + int'(cc));
    rd_addr = AW'(int'(rd_slot) * MAX_WIDTH + int'(rd_col));
    wr_addr = AW'(int'(sl_cur) * MAX_WIDTH + int'(x_cur));
  end

  assign sts.rd_last = (rr == span_l) && (cc == span_l);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rr <= '0;
      cc <= '0;
    end else if (cmd.rd_step) begin
      if (cc == span_l) begin
        cc <= '0;
        rr <= rr + SPAN_W'(1);
      end else begin
        cc <= cc + SPAN_W'(1);
      end
    end
  end

  lmv_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (cmd.accept),
    .waddr(wr_addr),
    .wdata(pixel),
    .re   (cmd.rd_step),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Sums, products and the difference for the variance numerator.
  logic [SB-1:0]    sum_s;
  logic [QB-1:0]    sum_q;
  logic [NUM_W-1:0] nq, ss, num;
  logic [DNW-1:0]   den;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_s <= '0;
      sum_q <= '0;
    end else if (rd_pend) begin
      sum_s <= sum_s + SB'(rd_data);
      sum_q <= sum_q + QB'(rd_data) * QB'(rd_data);
    end
    if (cmd.mul) begin
      nq  <= NUM_W'(n_reg) * NUM_W'(sum_q);
      ss  <= NUM_W'(sum_s) * NUM_W'(sum_s);
      den <= DNW'(n_reg) * DNW'(n_reg - NB'(1));
    end
    if (cmd.sub) begin
      num <= nq - ss;
    end
  end

  // Restoring divider, one quotient bit per cycle, shared by mean and variance.
  logic [DVW-1:0]   quo;
  logic [DNW-1:0]   rem;
  logic [DNW-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic [DNW:0]     rem_sh;

  assign rem_sh       = {rem, quo[DVW-1]};
  assign sts.div_busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_mean || cmd.div_var) begin
      cnt <= CNT_W'(DVW);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_mean) begin
      quo <= DVW'({sum_s, 8'b0});
      dvs <= DNW'(n_reg);
      rem <= '0;
    end else if (cmd.div_var) begin
      quo <= {num, 8'b0};
      dvs <= den;
      rem <= '0;
    end else if (cnt != '0) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= DNW'(rem_sh - {1'b0, dvs});
        quo <= {quo[DVW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DNW-1:0];
        quo <= {quo[DVW-2:0], 1'b0};
      end
    end
  end

  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  var_r;

  always_ff @(posedge clk) begin
    if (cmd.save_mean) begin
      mean_r <= (quo > DVW'(MEAN_MAX)) ? MEAN_MAX : quo[MEAN_W-1:0];
    end
    if (cmd.save_var) begin
      var_r <= (quo > DVW'(VAR_MAX)) ? VAR_MAX : quo[VAR_W-1:0];
    end
  end

  // Result register; it holds a beat while the next pixel is taken.
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      center_x    <= xl - X_W'(h_l);
      center_y    <= yl - ROW_W'(h_l);
      mean_q8     <= mean_r;
      variance_q8 <= var_r;
    end
  end
endmodule

// ===== tb/sv/local_mean_variance_filter_test.sv =====
// ----------------------------------------------------------------------------
// local_mean_variance_filter_test: self-checking bench of the window filter
// Streams raster frames under varied window and image geometry, predicts or
// tabulates each window mean and variance, and compares every result beat in order.
// ----------------------------------------------------------------------------
module local_mean_variance_filter_test;
  import lmv_pkg::*;

  localparam int STORE_ROWS = 2 * MAX_HALF_DEF + 1;
  // Longest busy stretch of one window pixel (h = 7) plus some margin.
  localparam int SETTLE_CYCLES = 330;
  localparam int ITEM_COUNT = 1850;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [9:0]       cx;
    logic [ROW_W-1:0] cy;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0] variance;
  } window_result_t;

  typedef struct {
    logic [7:0]        pix;
    bit                fs;
    bit                reconf;
    bit                typed;
    logic [9:0]        cx;
    logic [ROW_W-1:0]  cy;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lmv_in_if  in_ch();
  lmv_out_if out_ch();

  local_mean_variance_filter dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Mirror of the block: line store, raster position and registers.
  logic [7:0] pixel_rows [STORE_ROWS][MAX_WIDTH_DEF];
  int unsigned col_pos, row_pos;
  logic [HALF_W-1:0]  half_reg;
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;

  window_result_t window_q[$];
  int errors = 0;
  int items_sent = 0;
  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 0;

  const stim_row_t stim_rows[21] = '{
    // Reset geometry: the first columns complete no window.
    '{8'h00, 1'b1, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h5A, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    // Smallest image, 3x3 with h = 1: a flat white frame.
    '{8'hFF, 1'b1, 1'b1, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 10'd1, 12'd1, 16'd65280, 23'd0},
    // A flat black frame.
    '{8'h00, 1'b1, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 10'd0, 12'd0, 16'd0, 23'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 10'd1, 12'd1, 16'd0, 23'd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 5000000);
    $display("== FAIL ==");
    $finish;
  end

  // The long hold-off of the receiver runs on its own cycle count.
  initial begin
    forever begin
      wait (hold_req);
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 0;
    end
  end

  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    out_ch.ready <= hold_req ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin : watch
    window_result_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (window_q.size() == 0) begin
        report_mismatch("unexpected result beat, center_x", out_ch.center_x, -1);
      end else begin
        w = window_q.pop_front();
        if (out_ch.center_x !== w.cx) report_mismatch("center_x", out_ch.center_x, w.cx);
        if (out_ch.center_y !== w.cy) report_mismatch("center_y", out_ch.center_y, w.cy);
        if (out_ch.mean_q8 !== w.mean) report_mismatch("mean_q8", out_ch.mean_q8, w.mean);
        if (out_ch.variance_q8 !== w.variance) begin
          report_mismatch("variance_q8", out_ch.variance_q8, w.variance);
        end
      end
    end
  end

  // Works out the window result caused by one accepted pixel, if any.
  task automatic predict_window(input logic [7:0] pix, input bit fs, output bit hit,
                                output window_result_t res);
    int unsigned h, w, ht, x, y, span;
    longint unsigned s, q, n, v, mean, variance;
    h = (half_reg == 0) ? 1 : half_reg;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
    ht = (height_reg == 0) ? 1 : height_reg;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    x = (col_pos >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_pos;
    y = row_pos;
    pixel_rows[y % STORE_ROWS][x] = pix;
    span = 2 * h;
    hit = 0;
    res = '{default: '0};
    if (x >= span && y >= span) begin
      s = 0;
      q = 0;
      for (int unsigned r = y - span; r <= y; r++) begin
        for (int unsigned c = x - span; c <= x; c++) begin
          v = pixel_rows[r % STORE_ROWS][c];
          s += v;
          q += v * v;
        end
      end
      n = (span + 1) * (span + 1);
      mean = (s << 8) / n;
      if (mean > MEAN_MAX) mean = MEAN_MAX;
      variance = ((n * q - s * s) << 8) / (n * (n - 1));
      if (variance > VAR_MAX) variance = VAR_MAX;
      res.cx = 10'(x - h);
      res.cy = ROW_W'(y - h);
      res.mean = MEAN_W'(mean);
      res.variance = VAR_W'(variance);
      hit = 1;
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= ht) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endtask

  task automatic idle_cycle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (window_q.size() != 0) idle_cycle();
  endtask

  // Registers change only with the block idle, so let any window in flight finish.
  task automatic write_reg(input reg_index_t idx, input int unsigned value);
    wait_drained();
    repeat (SETTLE_CYCLES) idle_cycle();
    case (idx)
      REG_HALF_SIZE:    half_reg = HALF_W'(value);
      REG_IMAGE_WIDTH:  width_reg = IMG_W_W'(value);
      REG_IMAGE_HEIGHT: height_reg = IMG_H_W'(value);
      default: ;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned h, input int unsigned w, input int unsigned ht);
    write_reg(REG_HALF_SIZE, h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, ht);
  endtask

  task automatic send_pixel(input logic [7:0] pix, input bit fs, input bit typed,
                            input window_result_t typed_res);
    bit hit;
    window_result_t res;
    while ($urandom_range(99) < src_gap_pct) idle_cycle();
    in_ch.valid <= 1'b1;
    in_ch.pixel <= pix;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_window(pix, fs, hit, res);
    if (hit) window_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One frame of random content; noisy frames restart at random points.
  task automatic send_frame(input int count, input bit noisy, input bit first_fs);
    window_result_t none;
    bit fs;
    none = '{default: '0};
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) ? first_fs : (noisy && $urandom_range(99) < 3);
      send_pixel(random_pixel(), fs, 1'b0, none);
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_gap_pct = 60; sink_stall_pct = 0;  end
      2: begin src_gap_pct = 0;  sink_stall_pct = 60; end
      default: begin src_gap_pct = 8; sink_stall_pct = 8; end
    endcase
  endtask

  initial begin : main
    window_result_t typed_res;
    int unsigned h, w, ht, frames, len;
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_HALF_SIZE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel = '0;
    in_ch.frame_start = 1'b0;
    half_reg = 1;
    width_reg = 640;
    height_reg = 480;
    col_pos = 0;
    row_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].reconf) set_geometry(1, 3, 3);
      typed_res = '{stim_rows[i].cx, stim_rows[i].cy, stim_rows[i].mean,
                    stim_rows[i].variance};
      send_pixel(stim_rows[i].pix, stim_rows[i].fs, stim_rows[i].typed, typed_res);
    end

    // Half size zero acts as one; image smaller than the window emits nothing.
    set_geometry(0, 6, 5);
    send_frame(30, 1'b0, 1'b1);
    set_geometry(7, 5, 100);
    send_frame(30, 1'b0, 1'b1);
    // Shrink the width under a running position: it wraps on the next step.
    set_geometry(7, 20, 30);
    send_frame(47, 1'b0, 1'b1);
    write_reg(REG_IMAGE_WIDTH, 3);
    send_frame(12, 1'b0, 1'b0);
    // Width zero acts as one, height zero acts as one.
    set_geometry(1, 0, 9);
    send_frame(12, 1'b0, 1'b1);
    set_geometry(1, 10, 0);
    send_frame(25, 1'b0, 1'b1);
    // An oversized width clamps to the widest row; a small image then
    // continues from the row where that wrap left the position.
    set_geometry(1, 2047, 4095);
    send_frame(MAX_WIDTH_DEF, 1'b0, 1'b1);
    set_geometry(1, 3, 3);
    send_frame(9, 1'b0, 1'b0);

    phase = 0;
    while (phase < 4 || items_sent < ITEM_COUNT) begin
      set_idling(phase % 4);
      h = ($urandom_range(9) < 7) ? $urandom_range(2, 1) : $urandom_range(7, 3);
      w = 2 * h + 1 + $urandom_range(6);
      ht = 2 * h + 1 + $urandom_range(4);
      // The hold-off phase needs enough windows to fill the block.
      if (phase == 2) begin
        w = 2 * h + 7;
        ht = 2 * h + 5;
      end
      set_geometry(h, w, ht);
      if (phase == 2) hold_req = 1;
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames && (f == 0 || items_sent < ITEM_COUNT); f++) begin
        len = (phase != 2 && $urandom_range(5) == 0) ? $urandom_range(w * ht, 1) : w * ht;
        send_frame(len, $urandom_range(4) == 0, 1'b1);
        if (phase % 4 == 3) wait_drained();
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (window_q.size() != 0) report_mismatch("results never delivered", 0, window_q.size());
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
